// ----- src/crank_cam_signal_generator_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the crank/cam signal generator
// Shorthand for clocked concurrent checks, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef CRANK_CAM_SIGNAL_GENERATOR_CORE_ASSERT_SVH
`define CRANK_CAM_SIGNAL_GENERATOR_CORE_ASSERT_SVH

// condition holds at every edge outside reset
`define CCSG_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define CCSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ccsg_pkg.sv -----
// ----------------------------------------------------------------------------
// ccsg_pkg
// Types and constants shared by the crank/cam signal generator.
// ----------------------------------------------------------------------------
package ccsg_pkg;

  localparam int unsigned EdgeW  = 9;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TOOTH_COUNT    = 3'd0,
    REG_GAP_TEETH      = 3'd1,
    REG_CAM_START      = 3'd2,
    REG_CAM_LOW        = 3'd3,
    REG_CAM_HIGH       = 3'd4,
    REG_CAM_MODE       = 3'd5,
    REG_CAM_TABLE      = 3'd6,
    REG_INIT_CAM_PER   = 3'd7
  } ccsg_reg_e;

  localparam logic [ByteW-1:0] ToothCountRst = 8'd60;
  localparam logic [ByteW-1:0] GapTeethRst   = 8'd2;

  typedef struct packed {
    logic [ByteW-1:0] tooth_count;
    logic [ByteW-1:0] gap_teeth;
    logic [ByteW-1:0] cam_start;
    logic [ByteW-1:0] cam_low_period;
    logic [ByteW-1:0] cam_high_period;
    logic             cam_mode;
    logic [ByteW-1:0] initial_cam_period;
  } ccsg_cfg_t;

  typedef struct packed {
    logic [EdgeW-1:0] edge_counter;
    logic             cam_active;
    logic [EdgeW-1:0] cam_edge_counter;
    logic [ByteW-1:0] cam_period;
    logic [IdxW-1:0]  cam_index;
    logic             cam_line;
  } ccsg_state_t;

  typedef struct packed {
    logic             crank_pulse;
    logic             crank_hold_high;
    logic             rev_marker;
    logic             cam_level;
    logic [EdgeW-1:0] edge_position;
  } ccsg_res_t;

endpackage

// ----- src/ccsg_step.sv -----
// ----------------------------------------------------------------------------
// ccsg_step
// Next-state and result logic for one item of the trigger-wheel generator.
// ----------------------------------------------------------------------------
module ccsg_step import ccsg_pkg::*; #(
  parameter int unsigned CAM_TABLE_ENTRIES = 8
) (
  input  ccsg_cfg_t                                cfg_i,
  input  logic [CAM_TABLE_ENTRIES-1:0][ByteW-1:0]  cam_table_i,
  input  ccsg_state_t                              state_i,
  input  logic                                     tooth_edge_i,
  output ccsg_state_t                              state_o,
  output ccsg_res_t                                res_o
);

  logic [EdgeW-1:0] full;
  logic [EdgeW-1:0] gap;
  logic [EdgeW-1:0] ec_inc;
  logic [EdgeW:0]   act_thr;
  logic [ByteW-1:0] entry_sel;
  logic [ByteW-1:0] entry_use;
  logic [IdxW-1:0]  idx_use;
  logic             idx_hit;
  ccsg_state_t      st;

  assign full    = {cfg_i.tooth_count, 1'b0};
  assign gap     = {cfg_i.gap_teeth, 1'b0};
  assign ec_inc  = state_i.edge_counter + 1'b1;
  assign act_thr = {1'b0, cfg_i.cam_start, 1'b0} + {2'b00, cfg_i.gap_teeth};
  assign idx_hit = state_i.cam_index < IdxW'(CAM_TABLE_ENTRIES);

  always_comb begin
    entry_sel = '0;
    for (int i = 0; i < CAM_TABLE_ENTRIES; i++) begin
      if (state_i.cam_index == IdxW'(i)) begin
        entry_sel = cam_table_i[i];
      end
    end
  end

  always_comb begin
    st    = state_i;
    res_o = '0;
    idx_use   = state_i.cam_index;
    entry_use = entry_sel;
    if (!idx_hit || entry_sel == '0) begin
      idx_use   = '0;
      entry_use = cam_table_i[0];
    end

    if (tooth_edge_i) begin
      if (state_i.cam_active) begin
        st.cam_edge_counter = state_i.cam_edge_counter + 1'b1;
      end
      if (ec_inc < full) begin
        st.edge_counter = ec_inc;
        if (ec_inc < gap) begin
          res_o.crank_hold_high = 1'b1;
        end else begin
          res_o.crank_pulse = ec_inc[0];
        end
      end else begin
        st.edge_counter = '0;
      end

      res_o.rev_marker = ({1'b0, st.edge_counter} + 1'b1) == {1'b0, full};

      if (!state_i.cam_active && {1'b0, st.edge_counter} > act_thr) begin
        st.cam_active       = 1'b1;
        st.cam_edge_counter = '0;
        st.cam_period       = cfg_i.initial_cam_period;
      end

      if (st.cam_active && st.cam_edge_counter >= {st.cam_period, 1'b0}) begin
        if (cfg_i.cam_mode) begin
          st.cam_period = entry_use;
        end else begin
          st.cam_period = state_i.cam_line ? cfg_i.cam_low_period : cfg_i.cam_high_period;
        end
        st.cam_line         = ~state_i.cam_line;
        st.cam_edge_counter = '0;
        st.cam_index        = idx_use + 1'b1;
      end
    end

    res_o.cam_level     = st.cam_line;
    res_o.edge_position = st.edge_counter;
    state_o = st;
  end

endmodule

// ----- src/crank_cam_signal_generator_core.sv -----
// ----------------------------------------------------------------------------
// crank_cam_signal_generator_core
// Missing-tooth crank wheel and cam signal simulator, one edge per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries tooth_edge_i; one transfer
//   is one item, an edge or an idle slot. Each item yields exactly one result
//   on the output channel (out_valid_o/out_ready_i): crank pulse, gap hold,
//   revolution marker, cam level and the edge position after the item.
//   Each result is registered. Throughput is one item per cycle while the
//   receiver takes results, set by the combinational edge/cam counter update.
//   A two-entry output buffer (result register plus skid) sits between the
//   sides, so one more item is taken while a result waits; with both entries
//   full, in_ready_o drops until the receiver takes a result.
//   Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i while
//   the block is idle; a write takes effect at the next clock edge.
//   Reset clears all counters and the cam line and loads the register reset
//   values (60 teeth, 2 gap teeth, everything else zero).
// ----------------------------------------------------------------------------
`include "crank_cam_signal_generator_core_assert.svh"

module crank_cam_signal_generator_core import ccsg_pkg::*; #(
  parameter int unsigned CAM_TABLE_ENTRIES = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 tooth_edge_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 crank_pulse_o,
  output logic                 crank_hold_high_o,
  output logic                 rev_marker_o,
  output logic                 cam_level_o,
  output logic [EdgeW-1:0]     edge_position_o
);

  ccsg_cfg_t                               cfg_q;
  logic [CAM_TABLE_ENTRIES-1:0][ByteW-1:0] cam_table_q;
  ccsg_state_t                             state_q, state_d;
  ccsg_res_t                               res_new;
  ccsg_res_t                               out_q, skid_q;
  logic                                    out_vld_q, skid_vld_q;
  logic                                    in_xfer, out_free;

  assign in_ready_o = ~skid_vld_q;
  assign in_xfer    = in_valid_i & in_ready_o;
  assign out_free   = ~out_vld_q | out_ready_i;

  ccsg_step #(
    .CAM_TABLE_ENTRIES(CAM_TABLE_ENTRIES)
  ) u_step (
    .cfg_i       (cfg_q),
    .cam_table_i (cam_table_q),
    .state_i     (state_q),
    .tooth_edge_i(tooth_edge_i),
    .state_o     (state_d),
    .res_o       (res_new)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '{tooth_count: ToothCountRst, gap_teeth: GapTeethRst, default: '0};
      cam_table_q <= '0;
    end else if (cfg_we_i) begin
      case (ccsg_reg_e'(cfg_idx_i))
        REG_TOOTH_COUNT:  cfg_q.tooth_count        <= cfg_wdata_i[ByteW-1:0];
        REG_GAP_TEETH:    cfg_q.gap_teeth          <= cfg_wdata_i[ByteW-1:0];
        REG_CAM_START:    cfg_q.cam_start          <= cfg_wdata_i[ByteW-1:0];
        REG_CAM_LOW:      cfg_q.cam_low_period     <= cfg_wdata_i[ByteW-1:0];
        REG_CAM_HIGH:     cfg_q.cam_high_period    <= cfg_wdata_i[ByteW-1:0];
        REG_CAM_MODE:     cfg_q.cam_mode           <= cfg_wdata_i[0];
        REG_CAM_TABLE:    cam_table_q <= cfg_wdata_i[CAM_TABLE_ENTRIES*ByteW-1:0];
        REG_INIT_CAM_PER: cfg_q.initial_cam_period <= cfg_wdata_i[ByteW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q  <= skid_vld_q | in_xfer;
      skid_vld_q <= 1'b0;
    end else if (in_xfer) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_vld_q ? skid_q : res_new;
    end else if (in_xfer) begin
      skid_q <= res_new;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign crank_pulse_o     = out_q.crank_pulse;
  assign crank_hold_high_o = out_q.crank_hold_high;
  assign rev_marker_o      = out_q.rev_marker;
  assign cam_level_o       = out_q.cam_level;
  assign edge_position_o   = out_q.edge_position;

  `CCSG_ASSERT_ALWAYS(a_skid_behind_out, !skid_vld_q || out_vld_q, "skid full, output empty")
  `CCSG_ASSERT_ALWAYS(a_pulse_not_in_gap, !out_vld_q || !(out_q.crank_pulse && out_q.crank_hold_high), "pulse in gap")
  `CCSG_ASSERT_NEXT(a_idle_keeps_state, in_xfer && !tooth_edge_i, $stable(state_q), "idle item changed state")

endmodule
